### rtl/pdrs_pkg.sv
// ----------------------------------------------------------------------------
// pdrs_pkg
// Shared types, codes and constants for the planar dead reckoning steer unit.
// ----------------------------------------------------------------------------
package pdrs_pkg;

  // Default number of fraction bits of the fixed-point format
  localparam int unsigned FRAC_BITS = 16;

  // Command kinds
  typedef enum logic [2:0] {
    KIND_LOAD    = 3'd0,
    KIND_ADVANCE = 3'd1,
    KIND_SETVEL  = 3'd2,
    KIND_STEER   = 3'd3,
    KIND_ARRIVE  = 3'd4
  } pdrs_kind_e;

  // Input word
  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        elapsed_seconds;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
  } pdrs_in_t;

  // Output word
  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic               at_target;
  } pdrs_out_t;

  // Multiplier operand selection
  typedef enum logic [3:0] {
    MUL_VXT,  // vel_x * elapsed
    MUL_VYT,  // vel_y * elapsed
    MUL_VX2,  // |vel_x|^2
    MUL_VY2,  // |vel_y|^2
    MUL_HX2,  // (halved if far) |dx|^2
    MUL_HY2,  // (halved if far) |dy|^2
    MUL_AX2,  // |dx|^2
    MUL_AY2,  // |dy|^2
    MUL_R2,   // radius^2
    MUL_AXS,  // |dx| * speed
    MUL_AYS   // |dy| * speed
  } pdrs_mul_e;

  // Accumulator operation
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } pdrs_acc_e;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADV_M,
    ST_ADV_X,
    ST_ADV_Y,
    ST_SETV,
    ST_DIFF,
    ST_SP1,
    ST_SP2,
    ST_SP3,
    ST_SP4,
    ST_SP_W,
    ST_DS1,
    ST_DS2,
    ST_DS3,
    ST_DS4,
    ST_DS_W,
    ST_DZ,
    ST_ZV,
    ST_VX_D,
    ST_VX_W,
    ST_VY_M,
    ST_VY_D,
    ST_VY_W,
    ST_AR0,
    ST_AR2,
    ST_AR3,
    ST_AR4,
    ST_OUT
  } pdrs_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      capture;
    logic      load_item;
    pdrs_mul_e mul_sel;
    logic      adv_x;
    logic      adv_y;
    logic      diff;
    logic      set_vel;
    pdrs_acc_e acc_op;
    logic      sqrt_start;
    logic      speed_ld;
    logic      dist_ld;
    logic      zero_vel;
    logic      div_start;
    logic      velx_ld;
    logic      vely_ld;
    logic      hit_ld;
    logic      out_ld;
  } pdrs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] kind;
    logic       far;
    logic       dist_zero;
    logic       sqrt_done;
    logic       div_done;
    logic       out_free;
  } pdrs_stat_t;

endpackage

### rtl/planar_dead_reckoning_steer_unit.sv
// ----------------------------------------------------------------------------
// planar_dead_reckoning_steer_unit
// Position and velocity tracker on a plane with steering and arrival test.
// ----------------------------------------------------------------------------
// Work: steer runs two 32-step roots and two 64-step divides.
// Throughput: one word at a time; the next word is taken once the result
//   sits in the output register.
// Reset: position and velocity clear to zero, arrive radius to 1.0.
module planar_dead_reckoning_steer_unit #(
  parameter int unsigned FracBits = pdrs_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pdrs_pkg::pdrs_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pdrs_pkg::pdrs_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [30:0]        cfg_wdata_i
);
  import pdrs_pkg::*;

  pdrs_cmd_t  cmd;
  pdrs_stat_t stat;

  // Sequencer
  pdrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath
  pdrs_datapath #(
    .FracBits (FracBits)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/pdrs_isqrt.sv
// ----------------------------------------------------------------------------
// pdrs_isqrt
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pdrs_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] op_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] op_q, op_d;
  logic [34:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [34:0] rem_n, trial;

  // One digit step
  always_comb begin
    rem_n  = {rem_q[32:0], op_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      op_d   = op_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      op_d = {op_q[61:0], 2'b00};
      if (rem_n >= trial) begin
        rem_d  = rem_n - trial;
        root_d = {root_q[30:0], 1'b1};
      end else begin
        rem_d  = rem_n;
        root_d = {root_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### rtl/pdrs_div.sv
// ----------------------------------------------------------------------------
// pdrs_div
// Restoring divider, 64-bit dividend by 33-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pdrs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] num_q, num_d;
  logic [32:0] den_q, den_d;
  logic [32:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] rs, diff;

  // One quotient bit per step
  always_comb begin
    rs     = {rem_q, num_q[63]};
    diff   = rs - {1'b0, den_q};
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rs >= {1'b0, den_q}) begin
        rem_d = diff[32:0];
        num_d = {num_q[62:0], 1'b1};
      end else begin
        rem_d = rs[32:0];
        num_d = {num_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

### rtl/pdrs_datapath.sv
// ----------------------------------------------------------------------------
// pdrs_datapath
// State registers, shared multiplier, accumulator, root and divide units,
// and the output register.
// ----------------------------------------------------------------------------
module pdrs_datapath #(
  parameter int unsigned FracBits = pdrs_pkg::FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdrs_pkg::pdrs_in_t  in_data_i,
  input  logic                cfg_we_i,
  input  logic [30:0]         cfg_wdata_i,
  input  pdrs_pkg::pdrs_cmd_t cmd_i,
  output pdrs_pkg::pdrs_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pdrs_pkg::pdrs_out_t out_data_o
);
  import pdrs_pkg::*;

  localparam logic [30:0] RadiusRst = 31'(64'd1 << FracBits);

  pdrs_in_t           item_q;
  logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic [30:0]        radius_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [65:0] prod_q;
  logic [63:0]        acc_q;
  logic [31:0]        speed_q;
  logic [32:0]        dist_q;
  logic               hit_q;
  logic               out_valid_q;
  pdrs_out_t          out_q;

  logic [31:0]        ax, ay, avx, avy, hx, hy;
  logic               far;
  logic signed [32:0] mul_a, mul_b;
  logic               sqrt_done, div_done;
  logic [31:0]        root;
  logic [63:0]        quot;

  // Saturating position update
  function automatic logic signed [31:0] sat_add(logic signed [31:0] p,
                                                  logic signed [65:0] m);
    logic signed [49:0] s;
    s = $signed({{18{p[31]}}, p}) + $signed(m[49:0]);
    if (s > 50'sd2147483647) return 32'sh7fffffff;
    if (s < -50'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Signed, saturated steering component
  function automatic logic signed [31:0] sat_q(logic [63:0] q, logic neg);
    if (!neg) begin
      if (q > 64'h7fffffff) return 32'sh7fffffff;
      return q[31:0];
    end
    if (q >= 64'h80000000) return 32'sh80000000;
    return -q[31:0];
  endfunction

  // Magnitudes
  assign ax  = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
  assign ay  = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
  assign avx = vel_x_q[31] ? -vel_x_q : vel_x_q;
  assign avy = vel_y_q[31] ? -vel_y_q : vel_y_q;
  assign far = ax[31] | ay[31];
  assign hx  = far ? {1'b0, ax[31:1]} : ax;
  assign hy  = far ? {1'b0, ay[31:1]} : ay;

  // Multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_VXT: begin mul_a = {vel_x_q[31], vel_x_q}; mul_b = {17'b0, item_q.elapsed_seconds}; end
      MUL_VYT: begin mul_a = {vel_y_q[31], vel_y_q}; mul_b = {17'b0, item_q.elapsed_seconds}; end
      MUL_VX2: begin mul_a = {1'b0, avx}; mul_b = {1'b0, avx}; end
      MUL_VY2: begin mul_a = {1'b0, avy}; mul_b = {1'b0, avy}; end
      MUL_HX2: begin mul_a = {1'b0, hx}; mul_b = {1'b0, hx}; end
      MUL_HY2: begin mul_a = {1'b0, hy}; mul_b = {1'b0, hy}; end
      MUL_AX2: begin mul_a = {1'b0, ax}; mul_b = {1'b0, ax}; end
      MUL_AY2: begin mul_a = {1'b0, ay}; mul_b = {1'b0, ay}; end
      MUL_R2:  begin mul_a = {2'b0, radius_q}; mul_b = {2'b0, radius_q}; end
      MUL_AXS: begin mul_a = {1'b0, ax}; mul_b = {1'b0, speed_q}; end
      MUL_AYS: begin mul_a = {1'b0, ay}; mul_b = {1'b0, speed_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Shared iterative units
  pdrs_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .op_i    (acc_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  pdrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q[63:0]),
    .den_i   (dist_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Architectural state and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      vel_x_q  <= '0;
      vel_y_q  <= '0;
      radius_q <= RadiusRst;
    end else begin
      if (cfg_we_i) radius_q <= cfg_wdata_i;
      if (cmd_i.load_item) begin
        pos_x_q <= item_q.value_x;
        pos_y_q <= item_q.value_y;
      end
      if (cmd_i.adv_x) pos_x_q <= sat_add(pos_x_q, prod_q);
      if (cmd_i.adv_y) pos_y_q <= sat_add(pos_y_q, prod_q);
      if (cmd_i.load_item || cmd_i.set_vel) begin
        vel_x_q <= item_q.speed_x;
        vel_y_q <= item_q.speed_y;
      end
      if (cmd_i.zero_vel) begin
        vel_x_q <= '0;
        vel_y_q <= '0;
      end
      if (cmd_i.velx_ld) vel_x_q <= sat_q(quot, dx_q[32]);
      if (cmd_i.vely_ld) vel_y_q <= sat_q(quot, dy_q[32]);
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.capture) begin
      item_q <= in_data_i;
      hit_q  <= 1'b0;
    end
    if (cmd_i.diff) begin
      dx_q <= {item_q.value_x[31], item_q.value_x} - {pos_x_q[31], pos_x_q};
      dy_q <= {item_q.value_y[31], item_q.value_y} - {pos_y_q[31], pos_y_q};
    end
    case (cmd_i.acc_op)
      ACC_LOAD: acc_q <= prod_q[63:0];
      ACC_ADD:  acc_q <= acc_q + prod_q[63:0];
      default:  acc_q <= acc_q;
    endcase
    if (cmd_i.speed_ld) speed_q <= root;
    if (cmd_i.dist_ld)  dist_q  <= far ? {root, 1'b0} : {1'b0, root};
    if (cmd_i.hit_ld)   hit_q   <= (acc_q <= prod_q[63:0]);
    if (cmd_i.out_ld) begin
      out_q.out_pos_x <= pos_x_q;
      out_q.out_pos_y <= pos_y_q;
      out_q.out_vel_x <= vel_x_q;
      out_q.out_vel_y <= vel_y_q;
      out_q.at_target <= hit_q;
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.kind      = item_q.kind;
  assign stat_o.far       = far;
  assign stat_o.dist_zero = (dist_q == '0);
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.div_done  = div_done;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule

### rtl/pdrs_ctrl.sv
// ----------------------------------------------------------------------------
// pdrs_ctrl
// Command sequencer: steps the datapath through one input word at a time.
// ----------------------------------------------------------------------------
module pdrs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pdrs_pkg::pdrs_stat_t stat_i,
  output pdrs_pkg::pdrs_cmd_t  cmd_o
);
  import pdrs_pkg::*;

  pdrs_state_e state_q, state_d;
  logic        accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state; kind is decoded after capture
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        state_d = accept ? ST_LOAD : ST_IDLE;
      end
      ST_LOAD: begin
        state_d = (stat_i.kind == KIND_LOAD) ? ST_OUT : ST_ADV_M;
      end
      ST_ADV_M: state_d = ST_ADV_X;
      ST_ADV_X: state_d = ST_ADV_Y;
      ST_ADV_Y: begin
        if (stat_i.kind == KIND_SETVEL) begin
          state_d = ST_SETV;
        end else if (stat_i.kind == KIND_STEER || stat_i.kind == KIND_ARRIVE) begin
          state_d = ST_DIFF;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SETV:  state_d = ST_OUT;
      ST_DIFF:  state_d = (stat_i.kind == KIND_STEER) ? ST_SP1 : ST_AR0;
      ST_SP1:   state_d = ST_SP2;
      ST_SP2:   state_d = ST_SP3;
      ST_SP3:   state_d = ST_SP4;
      ST_SP4:   state_d = ST_SP_W;
      ST_SP_W:  if (stat_i.sqrt_done) state_d = ST_DS1;
      ST_DS1:   state_d = ST_DS2;
      ST_DS2:   state_d = ST_DS3;
      ST_DS3:   state_d = ST_DS4;
      ST_DS4:   state_d = ST_DS_W;
      ST_DS_W:  if (stat_i.sqrt_done) state_d = ST_DZ;
      ST_DZ:    state_d = stat_i.dist_zero ? ST_ZV : ST_VX_D;
      ST_ZV:    state_d = ST_OUT;
      ST_VX_D:  state_d = ST_VX_W;
      ST_VX_W:  if (stat_i.div_done) state_d = ST_VY_M;
      ST_VY_M:  state_d = ST_VY_D;
      ST_VY_D:  state_d = ST_VY_W;
      ST_VY_W:  if (stat_i.div_done) state_d = ST_OUT;
      ST_AR0:   state_d = stat_i.far ? ST_OUT : ST_AR2;
      ST_AR2:   state_d = ST_AR3;
      ST_AR3:   state_d = ST_AR4;
      ST_AR4:   state_d = ST_OUT;
      ST_OUT:   if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_VXT;
    cmd_o.acc_op  = ACC_HOLD;
    case (state_q)
      ST_IDLE:  cmd_o.capture = accept;
      ST_LOAD:  cmd_o.load_item = (stat_i.kind == KIND_LOAD);
      ST_ADV_M: cmd_o.mul_sel = MUL_VXT;
      ST_ADV_X: begin
        cmd_o.adv_x   = 1'b1;
        cmd_o.mul_sel = MUL_VYT;
      end
      ST_ADV_Y: cmd_o.adv_y = 1'b1;
      ST_SETV:  cmd_o.set_vel = 1'b1;
      ST_DIFF:  cmd_o.diff = 1'b1;
      ST_SP1:   cmd_o.mul_sel = MUL_VX2;
      ST_SP2: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_sel = MUL_VY2;
      end
      ST_SP3:   cmd_o.acc_op = ACC_ADD;
      ST_SP4:   cmd_o.sqrt_start = 1'b1;
      ST_SP_W:  cmd_o.speed_ld = stat_i.sqrt_done;
      ST_DS1:   cmd_o.mul_sel = MUL_HX2;
      ST_DS2: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_sel = MUL_HY2;
      end
      ST_DS3:   cmd_o.acc_op = ACC_ADD;
      ST_DS4:   cmd_o.sqrt_start = 1'b1;
      ST_DS_W:  cmd_o.dist_ld = stat_i.sqrt_done;
      ST_DZ:    cmd_o.mul_sel = MUL_AXS;
      ST_ZV:    cmd_o.zero_vel = 1'b1;
      ST_VX_D:  cmd_o.div_start = 1'b1;
      ST_VX_W:  cmd_o.velx_ld = stat_i.div_done;
      ST_VY_M:  cmd_o.mul_sel = MUL_AYS;
      ST_VY_D:  cmd_o.div_start = 1'b1;
      ST_VY_W:  cmd_o.vely_ld = stat_i.div_done;
      ST_AR0:   cmd_o.mul_sel = MUL_AX2;
      ST_AR2: begin
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.mul_sel = MUL_AY2;
      end
      ST_AR3: begin
        cmd_o.acc_op  = ACC_ADD;
        cmd_o.mul_sel = MUL_R2;
      end
      ST_AR4:   cmd_o.hit_ld = 1'b1;
      ST_OUT:   cmd_o.out_ld = stat_i.out_free;
      default:  cmd_o.capture = 1'b0;
    endcase
  end

endmodule

### rtl/pdrs_checker.sv
// ----------------------------------------------------------------------------
// pdrs_checker
// Port-level checks for the steer unit, attached by bind.
// ----------------------------------------------------------------------------
module pdrs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pdrs_pkg::pdrs_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pdrs_pkg::pdrs_out_t out_data_o,
  input logic                cfg_we_i,
  input logic [30:0]         cfg_wdata_i
);
  import pdrs_pkg::*;

  // Held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // Held result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // One word at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");

  // Handshake outputs always known out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o}))
    else $error("handshake output unknown");

endmodule

bind planar_dead_reckoning_steer_unit pdrs_checker u_pdrs_checker (.*);
